// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned SqrtSteps = 15;
  localparam int unsigned DivSteps  = 23;
  localparam int unsigned RadW      = 2 * SqrtSteps;
  localparam int unsigned RootW     = SqrtSteps;
  localparam int unsigned SqRemW    = RootW + 1;
  localparam int unsigned MagW      = 17;
  localparam int unsigned NumW      = MagW + 12;
  localparam int unsigned DivRemW   = RootW;
  localparam int unsigned NumHiW    = NumW - DivSteps;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } rmq_branch_e;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_req_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [1:0]         case_taken;
    logic               degenerate;
  } rmq_rsp_t;

  typedef struct packed {
    rmq_branch_e branch;
    logic        degen;
    logic [2:0]  neg;
  } rmq_tag_t;

  typedef struct packed {
    rmq_tag_t             tag;
    logic [2:0][MagW-1:0] mag;
  } rmq_ctx_t;

endpackage

// ===== design/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Branch select, radicand and off-diagonal pair magnitudes, registered.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmq_pkg::rmq_req_t  req_i,
  output logic               valid_o,
  output rmq_pkg::rmq_ctx_t  ctx_o,
  output logic [rmq_pkg::RadW-1:0] rad_o
);
  import rmq_pkg::*;

  logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [17:0] trace, rad;
  logic signed [17:0] d [3];
  rmq_ctx_t ctx_d, ctx_q;
  logic [RadW-1:0] rad_d, rad_q;
  logic valid_q;

  always_comb begin
    e00 = 18'(req_i.m00); e01 = 18'(req_i.m01); e02 = 18'(req_i.m02);
    e10 = 18'(req_i.m10); e11 = 18'(req_i.m11); e12 = 18'(req_i.m12);
    e20 = 18'(req_i.m20); e21 = 18'(req_i.m21); e22 = 18'(req_i.m22);
    trace = e00 + e11 + e22;
    if (trace > 18'sd0) begin
      ctx_d.tag.branch = BR_W;
      rad  = 18'sd16384 + trace;
      d[0] = e21 - e12;
      d[1] = e02 - e20;
      d[2] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      ctx_d.tag.branch = BR_X;
      rad  = 18'sd16384 + e00 - e11 - e22;
      d[0] = e21 - e12;
      d[1] = e01 + e10;
      d[2] = e02 + e20;
    end else if (e11 > e22) begin
      ctx_d.tag.branch = BR_Y;
      rad  = 18'sd16384 + e11 - e00 - e22;
      d[0] = e02 - e20;
      d[1] = e01 + e10;
      d[2] = e12 + e21;
    end else begin
      ctx_d.tag.branch = BR_Z;
      rad  = 18'sd16384 + e22 - e00 - e11;
      d[0] = e10 - e01;
      d[1] = e02 + e20;
      d[2] = e12 + e21;
    end
    ctx_d.tag.degen = (rad <= 18'sd0);
    for (int k = 0; k < 3; k++) begin
      ctx_d.tag.neg[k] = d[k][17];
      ctx_d.mag[k] = d[k][17] ? MagW'(-d[k]) : MagW'(d[k]);
    end
    rad_d = ctx_d.tag.degen ? '0 : {1'b0, rad[16:0], 12'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
    rad_q <= rad_d;
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign rad_o   = rad_q;

endmodule

// ===== design/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One root bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  rmq_pkg::rmq_ctx_t          ctx_i,
  input  logic [rmq_pkg::RadW-1:0]   rad_i,
  input  logic [rmq_pkg::SqRemW-1:0] rem_i,
  input  logic [rmq_pkg::RootW-1:0]  root_i,
  output logic                       valid_o,
  output rmq_pkg::rmq_ctx_t          ctx_o,
  output logic [rmq_pkg::RadW-1:0]   rad_o,
  output logic [rmq_pkg::SqRemW-1:0] rem_o,
  output logic [rmq_pkg::RootW-1:0]  root_o
);
  import rmq_pkg::*;

  logic [SqRemW+1:0] t, trial;
  logic ge;
  logic valid_q;
  rmq_ctx_t ctx_q;
  logic [RadW-1:0] rad_q;
  logic [SqRemW-1:0] rem_q;
  logic [RootW-1:0] root_q;

  always_comb begin
    t     = {rem_i, rad_i[RadW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    ge    = (t >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q  <= ctx_i;
    rad_q  <= {rad_i[RadW-3:0], 2'b00};
    rem_q  <= ge ? SqRemW'(t - trial) : SqRemW'(t);
    root_q <= {root_i[RootW-2:0], ge};
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

// ===== design/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of the restoring divider, for all three lanes.
// ----------------------------------------------------------------------------
module rmq_div_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  rmq_pkg::rmq_tag_t                     tag_i,
  input  logic [rmq_pkg::RootW-1:0]             s_i,
  input  logic [2:0][rmq_pkg::DivRemW-1:0]      rem_i,
  input  logic [2:0][rmq_pkg::DivSteps-1:0]     nq_i,
  output logic                                  valid_o,
  output rmq_pkg::rmq_tag_t                     tag_o,
  output logic [rmq_pkg::RootW-1:0]             s_o,
  output logic [2:0][rmq_pkg::DivRemW-1:0]      rem_o,
  output logic [2:0][rmq_pkg::DivSteps-1:0]     nq_o
);
  import rmq_pkg::*;

  logic [DivRemW:0] t [3];
  logic [2:0] ge;
  logic valid_q;
  rmq_tag_t tag_q;
  logic [RootW-1:0] s_q;
  logic [2:0][DivRemW-1:0] rem_q;
  logic [2:0][DivSteps-1:0] nq_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]  = {rem_i[k], nq_i[k][DivSteps-1]};
      ge[k] = (t[k] >= {1'b0, s_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_i;
    s_q   <= s_i;
    for (int k = 0; k < 3; k++) begin
      rem_q[k] <= ge[k] ? DivRemW'(t[k] - {1'b0, s_i}) : DivRemW'(t[k]);
      nq_q[k]  <= {nq_i[k][DivSteps-2:0], ge[k]};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// From start to valid_o a request passes the front, root, setup, divide and output stages in order.
// Throughput: one matrix per cycle; busy_o is always low.
// The root and divide stages are 15 square-root cells and 23 divider cells in one chain.
// Reset clears only the valid bits along the chain; no request is lost afterward.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion, Shepperd's method, Q2.14 fixed point.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rmq_pkg::rmq_req_t req_i,
  output logic              valid_o,
  output rmq_pkg::rmq_rsp_t rsp_o
);
  import rmq_pkg::*;

  logic                  sq_valid [SqrtSteps+1];
  rmq_ctx_t              sq_ctx   [SqrtSteps+1];
  logic [RadW-1:0]       sq_rad   [SqrtSteps+1];
  logic [SqRemW-1:0]     sq_rem   [SqrtSteps+1];
  logic [RootW-1:0]      sq_root  [SqrtSteps+1];

  logic                      dv_valid [DivSteps+1];
  rmq_tag_t                  dv_tag   [DivSteps+1];
  logic [RootW-1:0]          dv_s     [DivSteps+1];
  logic [2:0][DivRemW-1:0]   dv_rem   [DivSteps+1];
  logic [2:0][DivSteps-1:0]  dv_nq    [DivSteps+1];

  logic [NumW-1:0] num [3];
  logic setup_valid_q;
  rmq_tag_t setup_tag_q;
  logic [RootW-1:0] setup_s_q;
  logic [2:0][DivRemW-1:0] setup_rem_q;
  logic [2:0][DivSteps-1:0] setup_nq_q;

  logic signed [15:0] lane [3];
  logic signed [15:0] sq;
  rmq_rsp_t rsp_d, rsp_q;
  logic valid_q;

  assign busy_o = 1'b0;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .req_i   (req_i),
    .valid_o (sq_valid[0]),
    .ctx_o   (sq_ctx[0]),
    .rad_o   (sq_rad[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[i]),
      .ctx_i   (sq_ctx[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_valid[i+1]),
      .ctx_o   (sq_ctx[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {sq_ctx[SqrtSteps].mag[k], 12'b0}
             + NumW'(sq_root[SqrtSteps] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_valid_q <= 1'b0;
    end else begin
      setup_valid_q <= sq_valid[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    setup_tag_q <= sq_ctx[SqrtSteps].tag;
    setup_s_q   <= sq_root[SqrtSteps];
    for (int k = 0; k < 3; k++) begin
      setup_rem_q[k] <= DivRemW'(num[k][NumW-1 -: NumHiW]);
      setup_nq_q[k]  <= num[k][DivSteps-1:0];
    end
  end

  assign dv_valid[0] = setup_valid_q;
  assign dv_tag[0]   = setup_tag_q;
  assign dv_s[0]     = setup_s_q;
  assign dv_rem[0]   = setup_rem_q;
  assign dv_nq[0]    = setup_nq_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .tag_i   (dv_tag[i]),
      .s_i     (dv_s[i]),
      .rem_i   (dv_rem[i]),
      .nq_i    (dv_nq[i]),
      .valid_o (dv_valid[i+1]),
      .tag_o   (dv_tag[i+1]),
      .s_o     (dv_s[i+1]),
      .rem_o   (dv_rem[i+1]),
      .nq_o    (dv_nq[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_tag[DivSteps].neg[k]) begin
        lane[k] = (dv_nq[DivSteps][k] > DivSteps'(32768)) ? 16'sh8000
                : 16'(-dv_nq[DivSteps][k]);
      end else begin
        lane[k] = (dv_nq[DivSteps][k] > DivSteps'(32767)) ? 16'sh7fff
                : 16'(dv_nq[DivSteps][k]);
      end
    end
    sq = 16'(dv_s[DivSteps]);
    rsp_d.case_taken = dv_tag[DivSteps].branch;
    rsp_d.degenerate = dv_tag[DivSteps].degen;
    case (dv_tag[DivSteps].branch)
      BR_W: begin
        rsp_d.qx = lane[0]; rsp_d.qy = lane[1]; rsp_d.qz = lane[2]; rsp_d.qw = sq;
      end
      BR_X: begin
        rsp_d.qw = lane[0]; rsp_d.qy = lane[1]; rsp_d.qz = lane[2]; rsp_d.qx = sq;
      end
      BR_Y: begin
        rsp_d.qw = lane[0]; rsp_d.qx = lane[1]; rsp_d.qz = lane[2]; rsp_d.qy = sq;
      end
      default: begin
        rsp_d.qw = lane[0]; rsp_d.qx = lane[1]; rsp_d.qy = lane[2]; rsp_d.qz = sq;
      end
    endcase
    if (dv_tag[DivSteps].degen) begin
      rsp_d.qx = '0; rsp_d.qy = '0; rsp_d.qz = '0; rsp_d.qw = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== tb/rotation_matrix_to_quaternion_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_chk
// Watches the request and result channels of the matrix-to-quaternion
// pipeline, predicts each quaternion and compares it field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  rmq_pkg::rmq_req_t req_i,
  input  logic              valid_i,
  input  rmq_pkg::rmq_rsp_t rsp_i,
  output int                fail_cnt_o,
  output int                pending_o
);
  import rmq_pkg::*;

  rmq_rsp_t quat_q[$];

  function automatic longint root_floor(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] pair_scale(int d, longint s);
    longint mag, q;
    mag = (d < 0) ? -longint'(d) : longint'(d);
    q = ((mag << 12) + s / 2) / s;
    if (d < 0) return (q > 32768) ? -16'sd32768 : 16'(-q);
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic rmq_rsp_t quat_from_matrix(rmq_req_t m);
    int a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
    int d0, d1, d2;
    longint s;
    rmq_branch_e br;
    rmq_rsp_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      br = BR_W; rad = 16384 + tr;
      d0 = a21 - a12; d1 = a02 - a20; d2 = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X; rad = 16384 + a00 - a11 - a22;
      d0 = a21 - a12; d1 = a01 + a10; d2 = a02 + a20;
    end else if (a11 > a22) begin
      br = BR_Y; rad = 16384 + a11 - a00 - a22;
      d0 = a02 - a20; d1 = a01 + a10; d2 = a12 + a21;
    end else begin
      br = BR_Z; rad = 16384 + a22 - a00 - a11;
      d0 = a10 - a01; d1 = a02 + a20; d2 = a12 + a21;
    end
    r = '0;
    r.case_taken = br;
    r.degenerate = (rad <= 0);
    if (rad > 0) begin
      s = root_floor(longint'(rad) << 12);
      case (br)
        BR_W: begin
          r.qw = 16'(s); r.qx = pair_scale(d0, s);
          r.qy = pair_scale(d1, s); r.qz = pair_scale(d2, s);
        end
        BR_X: begin
          r.qx = 16'(s); r.qw = pair_scale(d0, s);
          r.qy = pair_scale(d1, s); r.qz = pair_scale(d2, s);
        end
        BR_Y: begin
          r.qy = 16'(s); r.qw = pair_scale(d0, s);
          r.qx = pair_scale(d1, s); r.qz = pair_scale(d2, s);
        end
        default: begin
          r.qz = 16'(s); r.qw = pair_scale(d0, s);
          r.qx = pair_scale(d1, s); r.qy = pair_scale(d2, s);
        end
      endcase
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rmq_rsp_t e;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (start_i && !busy_i) quat_q.push_back(quat_from_matrix(req_i));
      if (valid_i) begin
        if (quat_q.size() == 0) begin
          $error("unexpected result");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = quat_q.pop_front();
          if (rsp_i !== e) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (rsp_i.qx !== e.qx) $error("qx exp %0d got %0d", e.qx, rsp_i.qx);
            if (rsp_i.qy !== e.qy) $error("qy exp %0d got %0d", e.qy, rsp_i.qy);
            if (rsp_i.qz !== e.qz) $error("qz exp %0d got %0d", e.qz, rsp_i.qz);
            if (rsp_i.qw !== e.qw) $error("qw exp %0d got %0d", e.qw, rsp_i.qw);
            if (rsp_i.case_taken !== e.case_taken)
              $error("case_taken exp %0d got %0d", e.case_taken, rsp_i.case_taken);
            if (rsp_i.degenerate !== e.degenerate)
              $error("degenerate exp %0d got %0d", e.degenerate, rsp_i.degenerate);
          end
        end
      end
    end
  end

  assign pending_o = quat_q.size();
endmodule

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives directed and random matrices in bursts and gives the verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int Latency = 41;
  localparam int WatchLimit = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  rmq_req_t  req_i = '0;
  logic      valid_o;
  rmq_rsp_t  rsp_o;
  int        fail_cnt;
  int        pending;
  int        idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  rotation_matrix_to_quaternion dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .valid_o, .rsp_o
  );

  rotation_matrix_to_quaternion_chk u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .valid_i(valid_o),
    .rsp_i(rsp_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [15:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($signed($urandom_range(0, 2048)) - 1024);
      4: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Near-rotation (signed permutation matrix plus small noise), or one time in four random elements.
  function automatic rmq_req_t rnd_matrix();
    logic [15:0] e [9];
    int p, sg;
    if ($urandom_range(0, 3) == 0) begin
      foreach (e[i]) e[i] = rnd_elem();
    end else begin
      p = $urandom_range(0, 5);
      foreach (e[i]) e[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
      for (int r = 0; r < 3; r++) begin
        sg = $urandom_range(0, 1) ? 12000 : -12000;
        e[r * 3 + ((r + p + (p > 2 ? r : 0)) % 3)] += 16'(sg);
      end
    end
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic send(rmq_req_t m);
    start_i <= 1'b1;
    req_i   <= m;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  rmq_req_t dir_q[$];
  int burst;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    dir_q.push_back('0);
    dir_q.push_back({16'sd16384, 48'd0, 16'sd16384, 48'd0, 16'sd16384});
    dir_q.push_back({-16'sd16384, 48'd0, -16'sd16384, 48'd0, 16'sd16384});
    dir_q.push_back({16'sd16384, 48'd0, -16'sd16384, 48'd0, -16'sd16384});
    dir_q.push_back({-16'sd16384, 48'd0, 16'sd16384, 48'd0, -16'sd16384});
    dir_q.push_back({16'sd32767, {7{16'sd32767}}, 16'sd32767});
    dir_q.push_back({144{1'b1}} ^ {144{1'b1}} | {9{16'h8000}});
    dir_q.push_back({-16'sd100, 48'd0, -16'sd100, 48'd0, -16'sd100});
    dir_q.push_back({16'sd5, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd5,
                     16'sd32767, 16'sd32767, -16'sd32768, 16'sd5});
    dir_q.push_back({16'sd1, {3{16'h5555}}, 16'sd1, {3{16'haaaa}}, 16'sd1});
    dir_q.push_back({-16'sd32768, {3{16'sd32767}}, -16'sd32768, {3{16'sd7}},
                     -16'sd32768});
    dir_q.push_back({16'sd1, 48'd0, 16'sd0, 48'd0, -16'sd1});
    foreach (dir_q[i]) send(dir_q[i]);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int n = 0; n < 2000;) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) send(rnd_matrix());
      if ($urandom_range(0, 2) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_chk.sv
tb/rotation_matrix_to_quaternion_tb.sv
